// ----- rtl/awcr_pkg.sv -----
// shared types, codes and constants for the wall collision resolver
`timescale 1ns / 1ps

package awcr_pkg;

	localparam int CoordBits    = 16;
	localparam int RegBits      = 15;
	localparam int IdxBits      = 3;
	localparam int ActBits      = 2;
	localparam int WallSlotsDef = 8;

	// action codes
	localparam logic [ActBits-1:0] ActWrite      = 2'd0;
	localparam logic [ActBits-1:0] ActResolve    = 2'd1;
	localparam logic [ActBits-1:0] ActInvalidate = 2'd2;

	// register indexes
	localparam logic CfgRadius     = 1'b0;
	localparam logic CfgHalfHeight = 1'b1;

	typedef struct packed {
		logic [ActBits-1:0]          action;
		logic [IdxBits-1:0]          wall_index;
		logic signed [CoordBits-1:0] pos_x;
		logic signed [CoordBits-1:0] pos_y;
		logic signed [CoordBits-1:0] pos_z;
		logic signed [CoordBits-1:0] wall_min_x;
		logic signed [CoordBits-1:0] wall_min_y;
		logic signed [CoordBits-1:0] wall_min_z;
		logic signed [CoordBits-1:0] wall_max_x;
		logic signed [CoordBits-1:0] wall_max_y;
		logic signed [CoordBits-1:0] wall_max_z;
	} cmd_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] out_x;
		logic signed [CoordBits-1:0] out_y;
		logic signed [CoordBits-1:0] out_z;
		logic                        collided;
	} res_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] lo_x;
		logic signed [CoordBits-1:0] lo_y;
		logic signed [CoordBits-1:0] lo_z;
		logic signed [CoordBits-1:0] hi_x;
		logic signed [CoordBits-1:0] hi_y;
		logic signed [CoordBits-1:0] hi_z;
	} wall_t;

endpackage

// ----- rtl/aabb_wall_collision_resolver_core.sv -----
// top level: wall table and sequential aabb pushout resolver
`timescale 1ns / 1ps

// usage
// - command channel: a cmd transfer happens at a rising edge with start high and busy low
// - action write loads a wall box into slot wall_index and marks it valid; invalidate
//   clears the slot's valid bit; neither gives a result
// - a slot index at or above WALL_SLOTS and the unused action code are dropped silently
// - action resolve walks the wall slots in order, one slot per cycle through a single
//   shared overlap / penetration / push datapath, then saturates in the output state
// - a resolve: done rises after the slot walk and the output (saturate) state, and the result
//   transfers at the edge ending the done cycle; a new command can be taken at that same edge,
//   but not earlier: busy stays high through the whole slot walk and the output state
// - result channel: res is valid for exactly one cycle while done is high; there is no
//   backpressure, the receiver must take it in that cycle
// - config port: cfg_we writes cfg_wdata into register cfg_idx (0 player radius,
//   1 half height) at the edge; write only while busy is low and no done is pending
// - reset: valid bits cleared, radius 77 and half height 205 (q8.8), sequencer idle;
//   wall corner storage is not cleared, a slot only takes part in a walk once written
// - the walk keeps the corrected x and z at full width and clamps only at the output

module aabb_wall_collision_resolver_core #(
	parameter int WALL_SLOTS = awcr_pkg::WallSlotsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  awcr_pkg::cmd_t                cmd,
	output logic                          done,
	output awcr_pkg::res_t                res,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [awcr_pkg::RegBits-1:0]  cfg_wdata
);

	localparam int CB   = awcr_pkg::CoordBits;
	localparam int IdxW = (WALL_SLOTS > 1) ? $clog2(WALL_SLOTS) : 1;
	localparam int CntW = $clog2(WALL_SLOTS + 1);
	// corrected position plus up to one push of 2^(CB+1) per slot
	localparam int AccW = CB + 3 + $clog2(WALL_SLOTS + 1);
	localparam int CmpW = AccW + 1;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StWalk = 2'd1;
	localparam logic [1:0] StOut  = 2'd2;

	localparam logic signed [AccW-1:0] CMax = {{(AccW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [AccW-1:0] CMin = ~CMax;

	// control state
	logic [1:0]            state_q;
	logic [CntW-1:0]       slot_q;
	logic [WALL_SLOTS-1:0] vld_q;
	logic                  done_q;
	logic                  hit_q;

	// config registers
	logic [awcr_pkg::RegBits-1:0] radius_q;
	logic [awcr_pkg::RegBits-1:0] hh_q;

	// wall table and its registered read port
	awcr_pkg::wall_t mem [WALL_SLOTS];
	awcr_pkg::wall_t rd_q;

	// per-resolve working registers
	logic signed [CmpW-1:0] rx_lo_q, rx_hi_q, rz_lo_q, rz_hi_q;
	logic signed [CmpW-1:0] ry_lo_q, ry_hi_q;
	logic signed [AccW-1:0] cx_q, cz_q;
	logic signed [CB-1:0]   ry_q;
	logic signed [CmpW-1:0] rr_q;
	awcr_pkg::res_t         res_q;

	// command decode
	logic accept, acc_resolve, acc_write, acc_inval, slot_ok;
	logic [IdxW-1:0] wr_addr;

	assign accept      = start && !busy;
	assign slot_ok     = int'(cmd.wall_index) < WALL_SLOTS;
	assign acc_resolve = accept && (cmd.action == awcr_pkg::ActResolve);
	assign acc_write   = accept && (cmd.action == awcr_pkg::ActWrite) && slot_ok;
	assign acc_inval   = accept && (cmd.action == awcr_pkg::ActInvalidate) && slot_ok;
	assign wr_addr     = IdxW'(cmd.wall_index);

	// player box extents at accept time
	logic signed [CmpW-1:0] r_in, h_in, px_in, py_in, pz_in;
	assign r_in  = CmpW'($signed({1'b0, radius_q}));
	assign h_in  = CmpW'($signed({1'b0, hh_q}));
	assign px_in = CmpW'(cmd.pos_x);
	assign py_in = CmpW'(cmd.pos_y);
	assign pz_in = CmpW'(cmd.pos_z);

	// walk sequencing
	logic            walking, last_slot, rd_en;
	logic [CntW-1:0] slot_nxt;
	logic [IdxW-1:0] rd_addr;

	assign walking   = (state_q == StWalk);
	assign last_slot = (slot_q == CntW'(WALL_SLOTS - 1));
	assign slot_nxt  = slot_q + 1'b1;
	assign rd_en     = acc_resolve || (walking && !last_slot);
	assign rd_addr   = acc_resolve ? '0 : slot_nxt[IdxW-1:0];

	// shared slot datapath: overlap test against the current box, then
	// penetrations from the requested position and the push choice
	logic signed [CmpW-1:0] lox, loy, loz, hix, hiy, hiz;
	logic signed [CmpW-1:0] cxe, cze, cxp, cxm, czp, czm;
	logic signed [CmpW-1:0] flx, fhx, flz, fhz, px, pz, ax, az;
	logic                   ovl, ovx, ovz, push_x, push_z, slot_live;
	logic signed [AccW-1:0] cx_nxt, cz_nxt;

	always_comb begin
		lox = CmpW'(rd_q.lo_x);
		loy = CmpW'(rd_q.lo_y);
		loz = CmpW'(rd_q.lo_z);
		hix = CmpW'(rd_q.hi_x);
		hiy = CmpW'(rd_q.hi_y);
		hiz = CmpW'(rd_q.hi_z);
		cxe = CmpW'(cx_q);
		cze = CmpW'(cz_q);
		cxp = cxe + rr_q;
		cxm = cxe - rr_q;
		czp = cze + rr_q;
		czm = cze - rr_q;

		slot_live = vld_q[slot_q[IdxW-1:0]];
		ovl = slot_live && (cxp > lox) && (cxm < hix) && (ry_hi_q > loy) && (ry_lo_q < hiy)
			&& (czp > loz) && (czm < hiz);

		// penetration per axis, depth from the low side wins only if strictly smaller
		ovx = (rx_hi_q > lox) && (rx_lo_q < hix);
		ovz = (rz_hi_q > loz) && (rz_lo_q < hiz);
		flx = rx_hi_q - lox;
		fhx = hix - rx_lo_q;
		flz = rz_hi_q - loz;
		fhz = hiz - rz_lo_q;
		px  = !ovx ? '0 : ((flx < fhx) ? flx : -fhx);
		pz  = !ovz ? '0 : ((flz < fhz) ? flz : -fhz);
		ax  = px[CmpW-1] ? -px : px;
		az  = pz[CmpW-1] ? -pz : pz;

		// smaller nonzero axis takes the push
		push_x = ovl && (px != '0) && ((ax < az) || (pz == '0));
		push_z = ovl && !push_x && (pz != '0);
		cx_nxt = push_x ? (cx_q - AccW'(px)) : cx_q;
		cz_nxt = push_z ? (cz_q - AccW'(pz)) : cz_q;
	end

	// output clamp
	function automatic logic signed [CB-1:0] sat(input logic signed [AccW-1:0] v);
		logic signed [CB-1:0] r;
		if (v > CMax) begin
			r = CMax[CB-1:0];
		end else if (v < CMin) begin
			r = CMin[CB-1:0];
		end else begin
			r = v[CB-1:0];
		end
		return r;
	endfunction

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			slot_q   <= '0;
			vld_q    <= '0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			radius_q <= awcr_pkg::RegBits'(77);
			hh_q     <= awcr_pkg::RegBits'(205);
		end else begin
			// done is a registered copy of the output state flag
			done_q <= (state_q == StOut);
			if (cfg_we) begin
				unique case (cfg_idx)
					awcr_pkg::CfgRadius:     radius_q <= cfg_wdata;
					awcr_pkg::CfgHalfHeight: hh_q     <= cfg_wdata;
					default: ;
				endcase
			end
			if (acc_write) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (acc_inval) begin
				vld_q[wr_addr] <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (acc_resolve) begin
						state_q <= StWalk;
						slot_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				StWalk: begin
					if (ovl) begin
						hit_q <= 1'b1;
					end
					if (last_slot) begin
						state_q <= StOut;
					end else begin
						slot_q <= slot_nxt;
					end
				end
				StOut: begin
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// wall table: one write port from the command, one registered read for the walk
	always_ff @(posedge clk) begin
		if (acc_write) begin
			mem[wr_addr] <= '{lo_x: cmd.wall_min_x, lo_y: cmd.wall_min_y,
				lo_z: cmd.wall_min_z, hi_x: cmd.wall_max_x, hi_y: cmd.wall_max_y,
				hi_z: cmd.wall_max_z};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_resolve) begin
			rr_q    <= r_in;
			rx_lo_q <= px_in - r_in;
			rx_hi_q <= px_in + r_in;
			rz_lo_q <= pz_in - r_in;
			rz_hi_q <= pz_in + r_in;
			ry_lo_q <= py_in - h_in;
			ry_hi_q <= py_in + h_in;
			ry_q    <= cmd.pos_y;
			cx_q    <= AccW'(cmd.pos_x);
			cz_q    <= AccW'(cmd.pos_z);
		end else if (walking) begin
			cx_q <= cx_nxt;
			cz_q <= cz_nxt;
		end
		if (state_q == StOut) begin
			res_q <= '{out_x: sat(cx_q), out_y: ry_q, out_z: sat(cz_q), collided: hit_q};
		end
	end

	assign busy = (state_q != StIdle);
	assign done = done_q;
	assign res  = res_q;

	// the result strobe only ever shows once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while the sequencer is busy");

	// a taken resolve always occupies the sequencer
	a_resolve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_resolve |=> busy)
		else $error("resolve accepted but sequencer not busy");

	// every output cycle yields exactly one done strobe
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StOut) |=> (done && !busy))
		else $error("output cycle did not produce a done strobe");

	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// the walk never steps past the last slot
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> (slot_q < CntW'(WALL_SLOTS)))
		else $error("slot counter out of range during walk");

endmodule

// ----- verif/tb_aabb_wall_collision_resolver_core.sv -----
// self-checking testbench for the wall collision resolver: directed table, then random phases
`timescale 1ns / 1ps

module tb_aabb_wall_collision_resolver_core;

	localparam int WallSlots    = awcr_pkg::WallSlotsDef;
	// settle time covers a resolve's slot walk and output state, with margin on top
	localparam int SettleCycles = WallSlots + 4;
	localparam int QuietLimit   = 2000;
	localparam int PhaseItems   = 325;
	localparam int PhaseCount   = 6;
	localparam int MaxGap       = 10;
	localparam logic [awcr_pkg::ActBits-1:0] ActSpare = 2'd3;

	typedef struct {
		awcr_pkg::cmd_t c;
		bit             typed;
		awcr_pkg::res_t want;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	awcr_pkg::cmd_t                cmd = '0;
	logic                          done;
	awcr_pkg::res_t                res;
	logic                          cfg_we = 1'b0;
	logic                          cfg_idx = awcr_pkg::CfgRadius;
	logic [awcr_pkg::RegBits-1:0]  cfg_wdata = '0;

	// predictor state: wall table and the two registers
	longint wall_lo [WallSlots][3];
	longint wall_hi [WallSlots][3];
	bit     wall_live [WallSlots];
	longint radius_q88 = 77;
	longint height_q88 = 205;

	awcr_pkg::res_t pushout_due [$];
	stim_row_t      stim_table [$];
	int             mismatches = 0;
	int             quiet = 0;

	aabb_wall_collision_resolver_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic longint magnitude_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// signed depth of [c-r, c+r] into [lo, hi], zero when apart on this axis
	function automatic longint axis_depth(input longint c, input longint r,
			input longint lo, input longint hi);
		longint a;
		longint b;
		a = c - r;
		b = c + r;
		if (b > lo && a < hi) begin
			return (b - lo < hi - a) ? (b - lo) : -(hi - a);
		end
		return 0;
	endfunction

	function automatic logic signed [awcr_pkg::CoordBits-1:0] clamp_coord(input longint v);
		longint top;
		longint bottom;
		longint held;
		top = (longint'(1) << (awcr_pkg::CoordBits - 1)) - 1;
		bottom = -top - 1;
		held = (v > top) ? top : ((v < bottom) ? bottom : v);
		return held[awcr_pkg::CoordBits-1:0];
	endfunction

	// applies one command to the predictor's table, gives the pushout for a resolve
	task automatic predict_pushout(input awcr_pkg::cmd_t c, output bit produced,
			output awcr_pkg::res_t r);
		longint rx, ry, rz, cx, cz, px, pz;
		bit     hit;
		int     slot;
		slot = int'(c.wall_index);
		produced = 1'b0;
		r = '0;
		case (c.action)
			awcr_pkg::ActWrite: begin
				if (slot < WallSlots) begin
					wall_lo[slot][0] = longint'(c.wall_min_x);
					wall_lo[slot][1] = longint'(c.wall_min_y);
					wall_lo[slot][2] = longint'(c.wall_min_z);
					wall_hi[slot][0] = longint'(c.wall_max_x);
					wall_hi[slot][1] = longint'(c.wall_max_y);
					wall_hi[slot][2] = longint'(c.wall_max_z);
					wall_live[slot] = 1'b1;
				end
			end
			awcr_pkg::ActInvalidate: begin
				if (slot < WallSlots) begin
					wall_live[slot] = 1'b0;
				end
			end
			awcr_pkg::ActResolve: begin
				rx = longint'(c.pos_x);
				ry = longint'(c.pos_y);
				rz = longint'(c.pos_z);
				cx = rx;
				cz = rz;
				hit = 1'b0;
				for (int s = 0; s < WallSlots; s++) begin
					// strict overlap against the box around the corrected position
					if (wall_live[s] &&
							cx + radius_q88 > wall_lo[s][0] && cx - radius_q88 < wall_hi[s][0] &&
							ry + height_q88 > wall_lo[s][1] && ry - height_q88 < wall_hi[s][1] &&
							cz + radius_q88 > wall_lo[s][2] && cz - radius_q88 < wall_hi[s][2]) begin
						hit = 1'b1;
						// depths always taken from the requested position
						px = axis_depth(rx, radius_q88, wall_lo[s][0], wall_hi[s][0]);
						pz = axis_depth(rz, radius_q88, wall_lo[s][2], wall_hi[s][2]);
						if (px != 0 && (magnitude_of(px) < magnitude_of(pz) || pz == 0)) begin
							cx -= px;
						end else if (pz != 0) begin
							cz -= pz;
						end
					end
				end
				r.out_x = clamp_coord(cx);
				r.out_y = clamp_coord(ry);
				r.out_z = clamp_coord(cz);
				r.collided = hit;
				produced = 1'b1;
			end
			default: ;
		endcase
	endtask

	function automatic awcr_pkg::cmd_t random_raw_cmd();
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return awcr_pkg::cmd_t'(raw[$bits(awcr_pkg::cmd_t)-1:0]);
	endfunction

	function automatic awcr_pkg::cmd_t wall_cmd(input int slot, input int lx, input int ly,
			input int lz, input int hx, input int hy, input int hz);
		awcr_pkg::cmd_t c;
		c = random_raw_cmd();
		c.action = awcr_pkg::ActWrite;
		c.wall_index = slot[awcr_pkg::IdxBits-1:0];
		c.wall_min_x = lx[awcr_pkg::CoordBits-1:0];
		c.wall_min_y = ly[awcr_pkg::CoordBits-1:0];
		c.wall_min_z = lz[awcr_pkg::CoordBits-1:0];
		c.wall_max_x = hx[awcr_pkg::CoordBits-1:0];
		c.wall_max_y = hy[awcr_pkg::CoordBits-1:0];
		c.wall_max_z = hz[awcr_pkg::CoordBits-1:0];
		return c;
	endfunction

	function automatic awcr_pkg::cmd_t resolve_cmd(input int x, input int y, input int z);
		awcr_pkg::cmd_t c;
		c = random_raw_cmd();
		c.action = awcr_pkg::ActResolve;
		c.pos_x = x[awcr_pkg::CoordBits-1:0];
		c.pos_y = y[awcr_pkg::CoordBits-1:0];
		c.pos_z = z[awcr_pkg::CoordBits-1:0];
		return c;
	endfunction

	function automatic awcr_pkg::cmd_t drop_cmd(input int slot);
		awcr_pkg::cmd_t c;
		c = random_raw_cmd();
		c.action = awcr_pkg::ActInvalidate;
		c.wall_index = slot[awcr_pkg::IdxBits-1:0];
		return c;
	endfunction

	function automatic awcr_pkg::res_t pos_res(input int x, input int y, input int z,
			input bit hit);
		awcr_pkg::res_t r;
		r.out_x = x[awcr_pkg::CoordBits-1:0];
		r.out_y = y[awcr_pkg::CoordBits-1:0];
		r.out_z = z[awcr_pkg::CoordBits-1:0];
		r.collided = hit;
		return r;
	endfunction

	function automatic void add_row(input awcr_pkg::cmd_t c, input bit typed,
			input awcr_pkg::res_t want);
		stim_row_t row;
		row.c = c;
		row.typed = typed;
		row.want = want;
		stim_table = {stim_table, row};
	endfunction

	// random command: mostly boxes and positions near the origin so walls get hit
	function automatic awcr_pkg::cmd_t random_command();
		awcr_pkg::cmd_t c;
		int             roll;
		int             lx, ly, lz;
		c = random_raw_cmd();
		roll = $urandom_range(0, 99);
		if (roll < 38) begin
			c.action = awcr_pkg::ActWrite;
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				lx = int'($urandom_range(0, 6000)) - 3000;
				ly = int'($urandom_range(0, 3000)) - 1500;
				lz = int'($urandom_range(0, 6000)) - 3000;
				c.wall_min_x = lx[awcr_pkg::CoordBits-1:0];
				c.wall_min_y = ly[awcr_pkg::CoordBits-1:0];
				c.wall_min_z = lz[awcr_pkg::CoordBits-1:0];
				if (roll < 72) begin
					lx += $urandom_range(0, 1500);
					ly += $urandom_range(0, 1500);
					lz += $urandom_range(0, 1500);
				end else begin
					// inverted box on one axis at least
					lx -= $urandom_range(1, 500);
					ly += $urandom_range(0, 1500);
					lz -= $urandom_range(0, 500);
				end
				c.wall_max_x = lx[awcr_pkg::CoordBits-1:0];
				c.wall_max_y = ly[awcr_pkg::CoordBits-1:0];
				c.wall_max_z = lz[awcr_pkg::CoordBits-1:0];
			end
		end else if (roll < 78) begin
			c.action = awcr_pkg::ActResolve;
			if ($urandom_range(0, 9) < 8) begin
				lx = int'($urandom_range(0, 6000)) - 3000;
				ly = int'($urandom_range(0, 3000)) - 1500;
				lz = int'($urandom_range(0, 6000)) - 3000;
				c.pos_x = lx[awcr_pkg::CoordBits-1:0];
				c.pos_y = ly[awcr_pkg::CoordBits-1:0];
				c.pos_z = lz[awcr_pkg::CoordBits-1:0];
			end
		end else if (roll < 90) begin
			c.action = awcr_pkg::ActInvalidate;
		end else begin
			c.action = ActSpare;
		end
		return c;
	endfunction

	// one command transfer, then the prediction of what it causes
	task automatic issue(input awcr_pkg::cmd_t c, input int gap, input bit typed,
			input awcr_pkg::res_t want);
		bit             produced;
		awcr_pkg::res_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		predict_pushout(c, produced, predicted);
		if (produced) begin
			pushout_due = {pushout_due, typed ? want : predicted};
		end
	endtask

	// drain, let a table write finish, then load both registers
	task automatic settle_and_configure(input int radius, input int height);
		start <= 1'b0;
		while (pushout_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= awcr_pkg::CfgRadius;
		cfg_wdata <= radius[awcr_pkg::RegBits-1:0];
		@(posedge clk);
		radius_q88 = longint'(radius);
		cfg_idx <= awcr_pkg::CfgHalfHeight;
		cfg_wdata <= height[awcr_pkg::RegBits-1:0];
		@(posedge clk);
		height_q88 = longint'(height);
		cfg_we <= 1'b0;
	endtask

	// result side: every strobe is a transfer, matched against the oldest prediction
	always @(posedge clk) begin : check_results
		awcr_pkg::res_t want;
		if (arst_n && done) begin
			if (pushout_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %h", res));
			end else begin
				want = pushout_due.pop_front();
				if (res.out_x !== want.out_x)
					report_mismatch($sformatf("out_x %0d, expected %0d", res.out_x, want.out_x));
				if (res.out_y !== want.out_y)
					report_mismatch($sformatf("out_y %0d, expected %0d", res.out_y, want.out_y));
				if (res.out_z !== want.out_z)
					report_mismatch($sformatf("out_z %0d, expected %0d", res.out_z, want.out_z));
				if (res.collided !== want.collided)
					report_mismatch($sformatf("collided %b, expected %b",
						res.collided, want.collided));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int             radius;
		int             height;
		int             sent;
		int             draws;
		bit             calm;
		awcr_pkg::cmd_t c;

		for (int s = 0; s < WallSlots; s++) begin
			wall_live[s] = 1'b0;
		end

		// empty table, reset registers, position extremes
		add_row(resolve_cmd(0, 0, 0), 1'b1, pos_res(0, 0, 0, 1'b0));
		add_row(resolve_cmd(32767, -32768, -32768), 1'b1, pos_res(32767, -32768, -32768, 1'b0));
		add_row(resolve_cmd(-32768, 32767, 32767), 1'b1, pos_res(-32768, 32767, 32767, 1'b0));
		c = random_raw_cmd();
		c.action = ActSpare;
		add_row(c, 1'b0, '0);
		// a wall that only touches the player box
		add_row(wall_cmd(7, 77, -1000, -1000, 1000, 1000, 1000), 1'b0, '0);
		add_row(resolve_cmd(0, 0, 0), 1'b1, pos_res(0, 0, 0, 1'b0));
		// inverted box never overlaps
		add_row(wall_cmd(6, 100, 100, 100, -100, -100, -100), 1'b0, '0);
		add_row(resolve_cmd(0, 0, 0), 1'b1, pos_res(0, 0, 0, 1'b0));
		add_row(drop_cmd(7), 1'b0, '0);
		add_row(drop_cmd(6), 1'b0, '0);
		// push in x, then in z, then a wall hit only after the pushes, with no push
		add_row(wall_cmd(0, 50, -1000, -1000, 1000, 1000, 1000), 1'b0, '0);
		add_row(wall_cmd(1, -1000, -1000, 50, 1000, 1000, 1000), 1'b0, '0);
		add_row(wall_cmd(2, -500, -1000, -500, -90, 1000, -90), 1'b0, '0);
		add_row(resolve_cmd(0, 0, 0), 1'b0, '0);
		add_row(resolve_cmd(0, 5000, 0), 1'b1, pos_res(0, 5000, 0, 1'b0));
		add_row(drop_cmd(0), 1'b0, '0);
		add_row(drop_cmd(1), 1'b0, '0);
		add_row(drop_cmd(2), 1'b0, '0);
		// full-range wall: pushes past the coordinate range saturate
		add_row(wall_cmd(3, -32768, -32768, -32768, 32767, 32767, 32767), 1'b0, '0);
		add_row(resolve_cmd(32767, 0, 0), 1'b0, '0);
		add_row(resolve_cmd(-32768, 0, 0), 1'b0, '0);
		add_row(resolve_cmd(0, 0, 32767), 1'b0, '0);
		add_row(drop_cmd(3), 1'b0, '0);
		add_row(resolve_cmd(1234, -567, 89), 1'b1, pos_res(1234, -567, 89, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			issue(stim_table[i].c, $urandom_range(0, MaxGap), stim_table[i].typed,
				stim_table[i].want);
		end

		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0: begin radius = 0; height = 0; end
				1: begin radius = 32767; height = 32767; end
				2: begin radius = 77; height = 205; end
				3: begin radius = $urandom_range(0, 1023); height = $urandom_range(0, 1023); end
				4: begin radius = $urandom_range(0, 32767); height = $urandom_range(0, 32767); end
				default: begin radius = $urandom_range(0, 400); height = 32767; end
			endcase
			settle_and_configure(radius, height);
			sent = 0;
			draws = 0;
			calm = 1'b0;
			while (sent < PhaseItems) begin
				// stretches of back-to-back transfers now and then
				if (draws % 40 == 0) begin
					calm = ($urandom_range(0, 3) == 0);
				end
				c = random_command();
				issue(c, calm ? 0 : $urandom_range(0, MaxGap), 1'b0, '0);
				if (c.action != ActSpare) begin
					sent++;
				end
				draws++;
			end
		end

		start <= 1'b0;
		while (pushout_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (pushout_due.size() != 0) begin
			report_mismatch("expected results left over");
		end
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
